/* src/box_circle_penetration_macros.svh */
// Assertion helpers for the box/circle contact block.
// Each macro uses the clk_i and rst_ni of the module that expands it.
`ifndef BOX_CIRCLE_PENETRATION_MACROS_SVH
`define BOX_CIRCLE_PENETRATION_MACROS_SVH

`ifndef SYNTH
`define BCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("box_circle_penetration: check failed");
`define BCP_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("box_circle_penetration: check failed in reset");
`else
`define BCP_ASSERT(lbl, prop)
`define BCP_ASSERT_NR(lbl, prop)
`endif

`endif

/* src/bcp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bcp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE_Q14   = 16384;

  // Default skin is 0.15 in the coordinate format, rounded.
  localparam logic [30:0] SKIN_RESET = 31'(((15 << FRAC_BITS) + 50) / 100);

  localparam int SQRT_STEPS = 32;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;
  localparam int DIV_BITS   = 17;
  localparam int NUM_W      = 46;

  localparam logic signed [15:0] NRM_POS   = 16'sd16384;
  localparam logic signed [15:0] NRM_NEG   = -16'sd16384;
  localparam logic [31:0]        DEPTH_MAX = 32'h7fff_ffff;
  localparam logic [DIV_BITS-1:0] Q_ONE    = DIV_BITS'(ONE_Q14);

  typedef struct packed {
    logic               mode;
    logic signed [31:0] box_center_x;
    logic signed [31:0] box_center_y;
    logic [30:0]        box_width;
    logic [30:0]        box_height;
    logic signed [31:0] circle_center_x;
    logic signed [31:0] circle_center_y;
    logic [30:0]        circle_radius;
  } bcp_in_t;

  typedef struct packed {
    logic               overlap;
    logic               hit;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [31:0] depth;
  } bcp_out_t;

  // Per-item side data from the geometry front end to the normalize stages.
  typedef struct packed {
    logic               flip;
    logic               in_box;
    logic               touch;
    logic signed [15:0] in_nx;
    logic signed [15:0] in_ny;
    logic [31:0]        in_depth;
    logic               neg_x;
    logic               neg_y;
    logic [30:0]        mag_x;
    logic [30:0]        mag_y;
    logic [30:0]        r;
  } bcp_geo_t;

  // Side data that rides alongside the two dividers.
  typedef struct packed {
    logic               flip;
    logic               in_box;
    logic               touch;
    logic signed [15:0] in_nx;
    logic signed [15:0] in_ny;
    logic [31:0]        depth;
    logic               neg_x;
    logic               neg_y;
  } bcp_nrm_t;

endpackage

`default_nettype wire

/* src/bcp_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module bcp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  bcp_pkg::bcp_in_t  item_i,
  output logic              valid_o,
  output bcp_pkg::bcp_geo_t geo_o,
  output logic [63:0]       sq_o,
  output logic [63:0]       sqs_o
);
  import bcp_pkg::*;

  logic [7:0] v_q;

  // Stage 1: offsets of the circle center from the box center.
  logic signed [32:0] dx1_d, dy1_d, dx1_q, dy1_q;
  logic [29:0]        ex1_q, ey1_q;
  logic [30:0]        r1_q;
  logic               flip1_q;

  // Stage 2: magnitudes and signs.
  logic [32:0] adx2_d, ady2_d, adx2_q, ady2_q;
  logic        negx2_q, negy2_q, posx2_q, posy2_q, flip2_q;
  logic [29:0] ex2_q, ey2_q;
  logic [30:0] r2_q;

  // Stage 3: clamp, inside test, face choice.
  logic              inx3, iny3, xmaj3;
  logic [32:0]       omx3, omy3, mx3_q, my3_q;
  logic              inside3_q, negx3_q, negy3_q, flip3_q;
  logic [29:0]       dist3_d, dist3_q;
  logic signed [15:0] nx3_d, ny3_d, nx3_q, ny3_q;
  logic [30:0]       r3_q;

  // Stages 4 to 8.
  bcp_geo_t    g4_d, g4_q, g5_q, g6_d, g6_q, g7_q, g8_q;
  logic [31:0] dsum4;
  logic        rng4_d, rng4_q, rng5_q;
  logic [30:0] m4_d, m4_q;
  logic [61:0] px5_q, py5_q, pr5_q;
  logic [4:0]  sh5_d, sh5_q;
  logic [62:0] sq6_d;
  logic [63:0] sq6_q, sq7_q, sq8_q;
  logic [61:0] px7_q, py7_q;
  logic [63:0] sqs8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[6:0], valid_i};
    end
  end

  assign dx1_d = $signed({item_i.circle_center_x[31], item_i.circle_center_x})
               - $signed({item_i.box_center_x[31], item_i.box_center_x});
  assign dy1_d = $signed({item_i.circle_center_y[31], item_i.circle_center_y})
               - $signed({item_i.box_center_y[31], item_i.box_center_y});

  assign adx2_d = dx1_q[32] ? unsigned'(-dx1_q) : unsigned'(dx1_q);
  assign ady2_d = dy1_q[32] ? unsigned'(-dy1_q) : unsigned'(dy1_q);

  always_comb begin
    inx3  = adx2_q <= {3'b000, ex2_q};
    iny3  = ady2_q <= {3'b000, ey2_q};
    omx3  = adx2_q - {3'b000, ex2_q};
    omy3  = ady2_q - {3'b000, ey2_q};
    xmaj3 = adx2_q > ady2_q;
    if (xmaj3) begin
      dist3_d = ex2_q - adx2_q[29:0];
      nx3_d   = posx2_q ? NRM_POS : NRM_NEG;
      ny3_d   = '0;
    end else begin
      // A center exactly at the box center falls here and points down in y.
      dist3_d = ey2_q - ady2_q[29:0];
      nx3_d   = '0;
      ny3_d   = posy2_q ? NRM_POS : NRM_NEG;
    end
  end

  always_comb begin
    dsum4          = {1'b0, r3_q} + {2'b00, dist3_q};
    g4_d.flip      = flip3_q;
    g4_d.in_box    = inside3_q;
    g4_d.touch     = 1'b0;
    g4_d.in_nx     = nx3_q;
    g4_d.in_ny     = ny3_q;
    g4_d.in_depth  = dsum4[31] ? DEPTH_MAX : dsum4;
    g4_d.neg_x     = negx3_q;
    g4_d.neg_y     = negy3_q;
    g4_d.mag_x     = mx3_q[30:0];
    g4_d.mag_y     = my3_q[30:0];
    g4_d.r         = r3_q;
    rng4_d = (mx3_q <= {2'b00, r3_q}) && (my3_q <= {2'b00, r3_q});
    m4_d   = (mx3_q[30:0] > my3_q[30:0]) ? mx3_q[30:0] : my3_q[30:0];
  end

  // Shift that brings the larger offset component up to bit 30.
  always_comb begin
    sh5_d = '0;
    for (int i = 0; i < 31; i++) begin
      if (m4_q[i]) begin
        sh5_d = 5'(30 - i);
      end
    end
  end

  always_comb begin
    sq6_d       = {1'b0, px5_q} + {1'b0, py5_q};
    g6_d        = g5_q;
    g6_d.touch  = g5_q.in_box || (rng5_q && (sq6_d <= {1'b0, pr5_q}));
    g6_d.mag_x  = g5_q.mag_x << sh5_q;
    g6_d.mag_y  = g5_q.mag_y << sh5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx1_q   <= dx1_d;
      dy1_q   <= dy1_d;
      ex1_q   <= item_i.box_width[30:1];
      ey1_q   <= item_i.box_height[30:1];
      r1_q    <= item_i.circle_radius;
      flip1_q <= item_i.mode;

      adx2_q  <= adx2_d;
      ady2_q  <= ady2_d;
      negx2_q <= dx1_q[32];
      negy2_q <= dy1_q[32];
      posx2_q <= !dx1_q[32] && (dx1_q != '0);
      posy2_q <= !dy1_q[32] && (dy1_q != '0);
      ex2_q   <= ex1_q;
      ey2_q   <= ey1_q;
      r2_q    <= r1_q;
      flip2_q <= flip1_q;

      mx3_q     <= inx3 ? '0 : omx3;
      my3_q     <= iny3 ? '0 : omy3;
      inside3_q <= inx3 && iny3;
      negx3_q   <= negx2_q;
      negy3_q   <= negy2_q;
      flip3_q   <= flip2_q;
      dist3_q   <= dist3_d;
      nx3_q     <= nx3_d;
      ny3_q     <= ny3_d;
      r3_q      <= r2_q;

      g4_q   <= g4_d;
      rng4_q <= rng4_d;
      m4_q   <= m4_d;

      g5_q   <= g4_q;
      rng5_q <= rng4_q;
      sh5_q  <= sh5_d;
      px5_q  <= 62'(g4_q.mag_x) * 62'(g4_q.mag_x);
      py5_q  <= 62'(g4_q.mag_y) * 62'(g4_q.mag_y);
      pr5_q  <= 62'(g4_q.r) * 62'(g4_q.r);

      g6_q  <= g6_d;
      sq6_q <= {1'b0, sq6_d};

      g7_q  <= g6_q;
      sq7_q <= sq6_q;
      px7_q <= 62'(g6_q.mag_x) * 62'(g6_q.mag_x);
      py7_q <= 62'(g6_q.mag_y) * 62'(g6_q.mag_y);

      g8_q   <= g7_q;
      sq8_q  <= sq7_q;
      sqs8_q <= {2'b00, px7_q} + {2'b00, py7_q};
    end
  end

  assign valid_o = v_q[7];
  assign geo_o   = g8_q;
  assign sq_o    = sq8_q;
  assign sqs_o   = sqs8_q;

endmodule

`default_nettype wire

/* src/bcp_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none

module bcp_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] rad_i,
  output logic [31:0] root_o
);
  import bcp_pkg::*;

  logic [63:0] rem_q [SQRT_STEPS];
  logic [63:0] res_q [SQRT_STEPS];
  logic [31:0] root_q;

  // One digit of the bitwise square root per stage, from the top bit pair down.
  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
    logic [63:0] rem_in, res_in, trial, rem_d, res_d;

    if (g == 0) begin : g_first
      assign rem_in = rad_i;
      assign res_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign res_in = res_q[g-1];
    end

    always_comb begin
      trial = res_in + BIT;
      if (rem_in >= trial) begin
        rem_d = rem_in - trial;
        res_d = (res_in >> 1) + BIT;
      end else begin
        rem_d = rem_in;
        res_d = res_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_d;
        res_q[g] <= res_d;
      end
    end
  end

  // Round to nearest: the remainder above the root means the half point is passed.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= res_q[SQRT_STEPS-1][31:0]
              + 32'(rem_q[SQRT_STEPS-1] > res_q[SQRT_STEPS-1]);
    end
  end

  assign root_o = root_q;

endmodule

`default_nettype wire

/* src/bcp_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module bcp_div (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic [bcp_pkg::NUM_W-1:0]    num_i,
  input  logic [31:0]                  den_i,
  output logic [bcp_pkg::DIV_BITS-1:0] quo_o
);
  import bcp_pkg::*;

  localparam int CMP_W = 32 + DIV_BITS - 1;

  logic [NUM_W-1:0]    rem_q [DIV_BITS];
  logic [31:0]         den_q [DIV_BITS];
  logic [DIV_BITS-1:0] quo_q [DIV_BITS];

  // Restoring division, one quotient bit per stage, most significant first.
  for (genvar g = 0; g < DIV_BITS; g++) begin : g_step
    localparam int K = DIV_BITS - 1 - g;
    logic [NUM_W-1:0]    rem_in, rem_d;
    logic [31:0]         den_in;
    logic [DIV_BITS-1:0] quo_in, quo_d;
    logic [CMP_W-1:0]    sub;
    logic                take;

    if (g == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    always_comb begin
      sub      = CMP_W'(den_in) << K;
      take     = CMP_W'(rem_in) >= sub;
      rem_d    = take ? NUM_W'(CMP_W'(rem_in) - sub) : rem_in;
      quo_d    = quo_in;
      quo_d[K] = take;
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_d;
        den_q[g] <= den_in;
        quo_q[g] <= quo_d;
      end
    end
  end

  assign quo_o = quo_q[DIV_BITS-1];

endmodule

`default_nettype wire

/* src/box_circle_penetration.sv */
// Channel   Direction  Handshake              Payload
// in        input      in_valid_i/in_stall_o  in_data_i   (box, circle, mode)
// out       output     out_valid_o/out_stall_i out_data_o (overlap, hit, normal, depth)
// cfg       input      cfg_we_i               cfg_wdata_i (skin threshold)
//
// The pipeline has 8 geometry stages, 33 square root stages, one
// numerator stage, 17 divider stages and the output register.
// One transaction enters per cycle when not stalled; the two square roots and the two
// dividers each run as their own pipelines side by side.
// A stall on the output freezes the whole pipeline while the output register
// holds a transaction; an empty output register never stalls the input.
// Reset clears all valid bits and loads the default skin threshold.
`timescale 1ns / 1ps
`default_nettype none
`include "box_circle_penetration_macros.svh"

module box_circle_penetration (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bcp_pkg::bcp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bcp_pkg::bcp_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [30:0]       cfg_wdata_i
);
  import bcp_pkg::*;

  logic        en;
  logic [30:0] skin_q;

  logic        fv;
  bcp_geo_t    fgeo;
  logic [63:0] sq, sqs;
  logic [31:0] root_sq, len;

  logic     gv_q  [SQRT_LAT];
  bcp_geo_t geo_q [SQRT_LAT];
  bcp_geo_t gl;

  logic             nv_q;
  bcp_nrm_t         n_d, n_q;
  logic [NUM_W-1:0] numx_q, numy_q;
  logic [31:0]      len_q;

  logic [DIV_BITS-1:0] qx, qy;
  logic     dv_q  [DIV_BITS];
  bcp_nrm_t nrm_q [DIV_BITS];
  bcp_nrm_t nl;

  logic [15:0]        cx, cy;
  logic signed [15:0] sx, sy, nx, ny;
  bcp_out_t           out_d, out_q;
  logic               out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skin_q <= SKIN_RESET;
    end else if (cfg_we_i) begin
      skin_q <= cfg_wdata_i;
    end
  end

  bcp_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .item_i  (in_data_i),
    .valid_o (fv),
    .geo_o   (fgeo),
    .sq_o    (sq),
    .sqs_o   (sqs)
  );

  bcp_isqrt u_sqrt_dist (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sq),
    .root_o (root_sq)
  );

  bcp_isqrt u_sqrt_len (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sqs),
    .root_o (len)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SQRT_LAT; i++) begin
        gv_q[i] <= 1'b0;
      end
      nv_q <= 1'b0;
      for (int i = 0; i < DIV_BITS; i++) begin
        dv_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (en) begin
      gv_q[0] <= fv;
      for (int i = 1; i < SQRT_LAT; i++) begin
        gv_q[i] <= gv_q[i-1];
      end
      nv_q    <= gv_q[SQRT_LAT-1];
      dv_q[0] <= nv_q;
      for (int i = 1; i < DIV_BITS; i++) begin
        dv_q[i] <= dv_q[i-1];
      end
      out_valid_q <= dv_q[DIV_BITS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      geo_q[0] <= fgeo;
      for (int i = 1; i < SQRT_LAT; i++) begin
        geo_q[i] <= geo_q[i-1];
      end
    end
  end

  assign gl = geo_q[SQRT_LAT-1];

  always_comb begin
    n_d.flip   = gl.flip;
    n_d.in_box = gl.in_box;
    n_d.touch  = gl.touch;
    n_d.in_nx  = gl.in_nx;
    n_d.in_ny  = gl.in_ny;
    n_d.depth  = gl.in_box ? gl.in_depth : ({1'b0, gl.r} - root_sq);
    n_d.neg_x  = gl.neg_x;
    n_d.neg_y  = gl.neg_y;
  end

  // Numerators carry the half divisor so the quotient rounds to nearest.
  always_ff @(posedge clk_i) begin
    if (en) begin
      n_q    <= n_d;
      numx_q <= {1'b0, gl.mag_x, 14'd0} + NUM_W'(len >> 1);
      numy_q <= {1'b0, gl.mag_y, 14'd0} + NUM_W'(len >> 1);
      len_q  <= len;
    end
  end

  bcp_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numx_q),
    .den_i (len_q),
    .quo_o (qx)
  );

  bcp_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (numy_q),
    .den_i (len_q),
    .quo_o (qy)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      nrm_q[0] <= n_q;
      for (int i = 1; i < DIV_BITS; i++) begin
        nrm_q[i] <= nrm_q[i-1];
      end
    end
  end

  assign nl = nrm_q[DIV_BITS-1];

  always_comb begin
    cx = (qx > Q_ONE) ? Q_ONE[15:0] : qx[15:0];
    cy = (qy > Q_ONE) ? Q_ONE[15:0] : qy[15:0];
    sx = nl.neg_x ? -$signed(cx) : $signed(cx);
    sy = nl.neg_y ? -$signed(cy) : $signed(cy);
    nx = nl.in_box ? nl.in_nx : sx;
    ny = nl.in_box ? nl.in_ny : sy;
    if (nl.flip) begin
      nx = -nx;
      ny = -ny;
    end
    out_d.overlap  = nl.touch;
    out_d.hit      = nl.touch && (nl.depth > {1'b0, skin_q});
    out_d.normal_x = nl.touch ? nx : '0;
    out_d.normal_y = nl.touch ? ny : '0;
    out_d.depth    = nl.touch ? $signed(nl.depth) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `BCP_ASSERT(a_hit_needs_overlap, out_valid_o && out_data_o.hit |-> out_data_o.overlap)
  `BCP_ASSERT(a_miss_is_zero, out_valid_o && !out_data_o.overlap |-> out_data_o.depth == '0 && out_data_o.normal_x == '0 && out_data_o.normal_y == '0)
  `BCP_ASSERT(a_depth_nonneg, out_valid_o && out_data_o.overlap |-> !out_data_o.depth[31])
  `BCP_ASSERT_NR(a_reset_empty, !rst_ni |-> !out_valid_o)

endmodule

`default_nettype wire
